// ===== rtl/tkih_pkg.sv =====
// Package for the tick-keyed input history block.
// Holds the transfer structs, opcode and state enums, and default sizes.
// No dependencies.
package tkih_pkg;

  localparam int TICK_W          = 64;
  localparam int ACT_W           = 32;
  localparam int DEPTH_DEF       = 32;
  localparam int ACTION_BITS_DEF = 32;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_LOOKUP  = 3'd1,
    OP_LATEST  = 3'd2,
    OP_CONFIRM = 3'd3,
    OP_LIST    = 3'd4,
    OP_PRUNE   = 3'd5,
    OP_CLEAR   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [TICK_W-1:0] tick;
    logic [ACT_W-1:0]  action_in;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic              found;
    logic              pending;
    logic [ACT_W-1:0]  action_out;
    logic              entry_valid;
    logic [TICK_W-1:0] entry_tick;
    logic              last;
  } out_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

endpackage

// ===== rtl/tkih_mem.sv =====
// Entry store: tick and action words, one write port, one registered read port.
// Depends on tkih_pkg.
module tkih_mem #(
  parameter int DEPTH = tkih_pkg::DEPTH_DEF,
  parameter int AW    = tkih_pkg::ACT_W,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [IW-1:0]               waddr_i,
  input  logic [tkih_pkg::TICK_W-1:0] wtick_i,
  input  logic [AW-1:0]               wact_i,
  input  logic [IW-1:0]               raddr_i,
  output logic [tkih_pkg::TICK_W-1:0] rtick_o,
  output logic [AW-1:0]               ract_o
);

  logic [tkih_pkg::TICK_W-1:0] tick_mem [DEPTH];
  logic [AW-1:0]               act_mem  [DEPTH];
  logic [tkih_pkg::TICK_W-1:0] rtick_q;
  logic [AW-1:0]               ract_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      tick_mem[waddr_i] <= wtick_i;
      act_mem[waddr_i]  <= wact_i;
    end
    rtick_q <= tick_mem[raddr_i];
    ract_q  <= act_mem[raddr_i];
  end

  assign rtick_o = rtick_q;
  assign ract_o  = ract_q;

endmodule

// ===== rtl/tkih_cmp.sv =====
// Shared 64-bit magnitude comparator used by push, lookup, confirm, list and prune.
// Depends on tkih_pkg.
module tkih_cmp (
  input  logic [tkih_pkg::TICK_W-1:0] a_i,
  input  logic [tkih_pkg::TICK_W-1:0] b_i,
  output tkih_pkg::cmp_t              res_o
);

  assign res_o.eq = (a_i == b_i);
  assign res_o.lt = (a_i < b_i);

endmodule

// ===== rtl/tkih_ctrl.sv =====
// Sequencer: ring pointers, watermark, read walk over the store, result register.
// Depends on tkih_pkg; drives tkih_mem and tkih_cmp from the top level.
module tkih_ctrl #(
  parameter int DEPTH = tkih_pkg::DEPTH_DEF,
  parameter int AW    = tkih_pkg::ACT_W,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  tkih_pkg::in_t               item_i,
  output logic                        res_strobe_o,
  output tkih_pkg::out_t              res_o,
  output logic                        mem_we_o,
  output logic [IW-1:0]               mem_waddr_o,
  output logic [tkih_pkg::TICK_W-1:0] mem_wtick_o,
  output logic [AW-1:0]               mem_wact_o,
  output logic [IW-1:0]               mem_raddr_o,
  input  logic [tkih_pkg::TICK_W-1:0] mem_rtick_i,
  input  logic [AW-1:0]               mem_ract_i,
  output logic [tkih_pkg::TICK_W-1:0] cmp_a_o,
  output logic [tkih_pkg::TICK_W-1:0] cmp_b_o,
  input  tkih_pkg::cmp_t              cmp_i
);

  localparam int TW = tkih_pkg::TICK_W;

  function automatic logic [IW-1:0] wrap_slot(input logic [IW-1:0] b,
                                              input logic [CW-1:0] p);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(p);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[IW-1:0];
  endfunction

  tkih_pkg::state_e state_q, state_d;
  tkih_pkg::op_e    op_q, op_d;
  logic [TW-1:0]    tick_q, tick_d;
  logic [AW-1:0]    act_q, act_d;
  logic             above_q, above_d;
  logic [IW-1:0]    base_q, base_d;
  logic [CW-1:0]    lim_q, lim_d;
  logic [CW-1:0]    ipos_q, ipos_d;
  logic             dvalid_q, dvalid_d;
  logic             dlast_q, dlast_d;
  logic [TW-1:0]    hold_q, hold_d;
  logic             have_q, have_d;
  logic [IW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [TW-1:0]    wm_q, wm_d;
  tkih_pkg::out_t   res_q, res_d;
  logic             strobe_q, strobe_d;
  logic             do_write;
  logic [tkih_pkg::ACT_W-1:0] ract_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tkih_pkg::ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      wm_q     <= '0;
      strobe_q <= 1'b0;
      dvalid_q <= 1'b0;
      dlast_q  <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      wm_q     <= wm_d;
      strobe_q <= strobe_d;
      dvalid_q <= dvalid_d;
      dlast_q  <= dlast_d;
      have_q   <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    tick_q  <= tick_d;
    act_q   <= act_d;
    above_q <= above_d;
    base_q  <= base_d;
    lim_q   <= lim_d;
    ipos_q  <= ipos_d;
    hold_q  <= hold_d;
    res_q   <= res_d;
  end

  always_comb begin
    ract_ext             = '0;
    ract_ext[AW-1:0]     = mem_ract_i;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    tick_d   = tick_q;
    act_d    = act_q;
    above_d  = above_q;
    base_d   = base_q;
    lim_d    = lim_q;
    ipos_d   = ipos_q;
    hold_d   = hold_q;
    have_d   = have_q;
    head_d   = head_q;
    count_d  = count_q;
    wm_d     = wm_q;
    res_d    = '0;
    strobe_d = 1'b0;
    dvalid_d = 1'b0;
    dlast_d  = 1'b0;
    do_write = 1'b0;
    cmp_a_o  = mem_rtick_i;
    cmp_b_o  = tick_q;
    mem_raddr_o = wrap_slot(base_q, ipos_q);

    case (state_q)
      tkih_pkg::ST_IDLE: begin
        cmp_a_o = wm_q;
        cmp_b_o = item_i.tick;
        if (start) begin
          op_d    = tkih_pkg::op_e'(item_i.opcode);
          tick_d  = item_i.tick;
          act_d   = item_i.action_in[AW-1:0];
          above_d = cmp_i.lt;
          base_d  = head_q;
          lim_d   = count_q;
          have_d  = 1'b0;
          ipos_d  = '0;
          case (tkih_pkg::op_e'(item_i.opcode))
            tkih_pkg::OP_PUSH: begin
              ipos_d  = count_q - CW'(1);
              state_d = (count_q == '0) ? tkih_pkg::ST_WRITE : tkih_pkg::ST_SCAN;
            end
            tkih_pkg::OP_LATEST, tkih_pkg::OP_LOOKUP,
            tkih_pkg::OP_LIST, tkih_pkg::OP_PRUNE: begin
              if (tkih_pkg::op_e'(item_i.opcode) == tkih_pkg::OP_LATEST) begin
                ipos_d = count_q - CW'(1);
              end
              if (count_q == '0) begin
                strobe_d   = 1'b1;
                res_d.last = 1'b1;
              end else begin
                state_d = tkih_pkg::ST_SCAN;
              end
            end
            tkih_pkg::OP_CONFIRM: begin
              if (cmp_i.lt) wm_d = item_i.tick;
              strobe_d   = 1'b1;
              res_d.last = 1'b1;
            end
            tkih_pkg::OP_CLEAR: begin
              head_d     = '0;
              count_d    = '0;
              wm_d       = '0;
              strobe_d   = 1'b1;
              res_d.last = 1'b1;
            end
            default: begin
              strobe_d   = 1'b1;
              res_d.last = 1'b1;
            end
          endcase
        end
      end

      tkih_pkg::ST_SCAN: begin
        if (ipos_q < lim_q) begin
          ipos_d   = ipos_q + CW'(1);
          dvalid_d = 1'b1;
          dlast_d  = (ipos_q == lim_q - CW'(1));
        end
        if (dvalid_q) begin
          case (op_q)
            tkih_pkg::OP_PUSH: begin
              do_write       = cmp_i.lt;
              res_d.accepted = cmp_i.lt;
              res_d.last     = 1'b1;
              strobe_d       = 1'b1;
              state_d        = tkih_pkg::ST_IDLE;
            end
            tkih_pkg::OP_LOOKUP: begin
              if (cmp_i.eq) begin
                res_d.found      = 1'b1;
                res_d.pending    = above_q;
                res_d.action_out = ract_ext;
                res_d.last       = 1'b1;
                strobe_d         = 1'b1;
                state_d          = tkih_pkg::ST_IDLE;
              end else if (dlast_q) begin
                res_d.last = 1'b1;
                strobe_d   = 1'b1;
                state_d    = tkih_pkg::ST_IDLE;
              end
            end
            tkih_pkg::OP_LATEST: begin
              res_d.found      = 1'b1;
              res_d.action_out = ract_ext;
              res_d.last       = 1'b1;
              strobe_d         = 1'b1;
              state_d          = tkih_pkg::ST_IDLE;
            end
            tkih_pkg::OP_LIST: begin
              cmp_a_o = wm_q;
              cmp_b_o = mem_rtick_i;
              if (cmp_i.lt) begin
                if (have_q) begin
                  res_d.entry_valid = 1'b1;
                  res_d.entry_tick  = hold_q;
                  strobe_d          = 1'b1;
                end
                hold_d = mem_rtick_i;
                have_d = 1'b1;
              end
              if (dlast_q) state_d = tkih_pkg::ST_FLUSH;
            end
            tkih_pkg::OP_PRUNE: begin
              if (cmp_i.lt) begin
                head_d  = wrap_slot(head_q, CW'(1));
                count_d = count_q - CW'(1);
              end
              if (!cmp_i.lt || dlast_q) begin
                res_d.last = 1'b1;
                strobe_d   = 1'b1;
                state_d    = tkih_pkg::ST_IDLE;
              end
            end
            default: begin
              res_d.last = 1'b1;
              strobe_d   = 1'b1;
              state_d    = tkih_pkg::ST_IDLE;
            end
          endcase
        end
      end

      tkih_pkg::ST_WRITE: begin
        do_write       = 1'b1;
        res_d.accepted = 1'b1;
        res_d.last     = 1'b1;
        strobe_d       = 1'b1;
        state_d        = tkih_pkg::ST_IDLE;
      end

      tkih_pkg::ST_FLUSH: begin
        res_d.entry_valid = have_q;
        res_d.entry_tick  = have_q ? hold_q : '0;
        res_d.last        = 1'b1;
        strobe_d          = 1'b1;
        state_d           = tkih_pkg::ST_IDLE;
      end

      default: begin
        state_d = tkih_pkg::ST_IDLE;
      end
    endcase

    if (count_q == CW'(DEPTH)) begin
      mem_waddr_o = head_q;
      if (do_write) head_d = wrap_slot(head_q, CW'(1));
    end else begin
      mem_waddr_o = wrap_slot(head_q, count_q);
      if (do_write) count_d = count_q + CW'(1);
    end
  end

  assign mem_we_o     = do_write;
  assign mem_wtick_o  = tick_q;
  assign mem_wact_o   = act_q;
  assign busy         = (state_q != tkih_pkg::ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

// ===== rtl/tick_keyed_input_history.sv =====
// Tick-keyed input history: bounded tick-ordered ring of action words with a watermark.
// Usage:
//   An operation is transferred at a rising edge with start high and busy low;
//   item_i carries opcode, tick and action_in. busy stays high while the
//   sequencer works and no new operation is taken meanwhile.
//   Each result sits on res_o for exactly one cycle with res_strobe_o high;
//   the receiver cannot stall, so nothing is ever held back. The final
//   result of an operation has last set; only list gives several results.
// Sequencing (N = live entries, one entry read per cycle from the single
// registered read port of the store, one shared 64-bit comparator):
//   confirm, clear, unused opcode, any operation but push on an empty buffer:
//     result in the cycle after the transfer, busy never rises.
//   push: reads the newest entry, writes if its tick is newer (an empty
//   buffer is written directly). latest: reads the newest entry.
//   lookup, prune: walk up to N entries from the oldest. list: all N, then a flush.
// Reset: asynchronous, active low; empties the buffer and zeroes the
// watermark at once. The store contents are not cleared; an entry is only
// read after it has been written.
// Depends on tkih_pkg, tkih_mem, tkih_cmp, tkih_ctrl.
module tick_keyed_input_history #(
  parameter int DEPTH       = tkih_pkg::DEPTH_DEF,
  parameter int ACTION_BITS = tkih_pkg::ACTION_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tkih_pkg::in_t  item_i,
  output logic           res_strobe_o,
  output tkih_pkg::out_t res_o
);

  localparam int AW = (ACTION_BITS > tkih_pkg::ACT_W) ? tkih_pkg::ACT_W : ACTION_BITS;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                        mem_we;
  logic [IW-1:0]               mem_waddr;
  logic [tkih_pkg::TICK_W-1:0] mem_wtick;
  logic [AW-1:0]               mem_wact;
  logic [IW-1:0]               mem_raddr;
  logic [tkih_pkg::TICK_W-1:0] mem_rtick;
  logic [AW-1:0]               mem_ract;
  logic [tkih_pkg::TICK_W-1:0] cmp_a;
  logic [tkih_pkg::TICK_W-1:0] cmp_b;
  tkih_pkg::cmp_t              cmp_res;

  tkih_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .IW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wtick_i (mem_wtick),
    .wact_i  (mem_wact),
    .raddr_i (mem_raddr),
    .rtick_o (mem_rtick),
    .ract_o  (mem_ract)
  );

  tkih_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  tkih_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wtick_o  (mem_wtick),
    .mem_wact_o   (mem_wact),
    .mem_raddr_o  (mem_raddr),
    .mem_rtick_i  (mem_rtick),
    .mem_ract_i   (mem_ract),
    .cmp_a_o      (cmp_a),
    .cmp_b_o      (cmp_b),
    .cmp_i        (cmp_res)
  );

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (res_strobe_o || busy))
    else $error("transfer neither answered nor started work");

  a_last_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last) |-> !busy)
    else $error("final result while sequencer still busy");

  a_nonlast_is_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.last) |-> (busy && res_o.entry_valid))
    else $error("non-final result outside a pending list walk");

endmodule

// ===== bench/testbench.sv =====
// Testbench for tick_keyed_input_history: drives opcodes through the start/busy
// handshake, predicts every result from its own copy of the history and checks
// each strobed result in order. Depends on tkih_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int          HIST_DEPTH     = tkih_pkg::DEPTH_DEF;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 40;
  localparam logic [2:0]  OP_UNUSED      = 3'd7;
  localparam logic [63:0] TICK_MAX       = '1;

  logic           clk_i        = 1'b0;
  logic           rst_ni       = 1'b0;
  logic           start        = 1'b0;
  tkih_pkg::in_t  item_i       = '0;
  logic           busy;
  logic           res_strobe_o;
  tkih_pkg::out_t res_o;

  logic [63:0]  hist_tick [HIST_DEPTH];
  logic [31:0]  hist_action [HIST_DEPTH];
  int unsigned  hist_oldest    = 0;
  int unsigned  hist_live      = 0;
  logic [63:0]  hist_watermark = '0;
  logic [63:0]  tick_base      = '0;

  tkih_pkg::out_t replies_due [$];
  int unsigned    mismatch_count = 0;
  int unsigned    stall_cycles   = 0;
  bit             no_gaps        = 1'b0;

  tick_keyed_input_history u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned slot_at(int unsigned pos);
    return (hist_oldest + pos) % HIST_DEPTH;
  endfunction

  function automatic logic [63:0] rand_tick();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] stored_tick();
    return hist_tick[slot_at($urandom_range(0, hist_live - 1))];
  endfunction

  function automatic logic [63:0] newest_tick();
    return (hist_live == 0) ? tick_base : hist_tick[slot_at(hist_live - 1)];
  endfunction

  function automatic void step_history(tkih_pkg::in_t cmd);
    tkih_pkg::out_t r;
    tkih_pkg::out_t e;
    int unsigned    s;
    int unsigned    listed;
    bit             hit;
    r        = '0;
    r.last   = 1'b1;
    listed   = 0;
    hit      = 1'b0;
    case (cmd.opcode)
      tkih_pkg::OP_PUSH: begin
        if (hist_live == 0 || cmd.tick > hist_tick[slot_at(hist_live - 1)]) begin
          if (hist_live >= HIST_DEPTH) begin
            s           = hist_oldest;
            hist_oldest = slot_at(1);
          end else begin
            s = slot_at(hist_live);
            hist_live++;
          end
          hist_tick[s]   = cmd.tick;
          hist_action[s] = cmd.action_in;
          r.accepted     = 1'b1;
        end
      end
      tkih_pkg::OP_LOOKUP: begin
        for (int unsigned i = 0; i < hist_live; i++) begin
          s = slot_at(i);
          if (!hit && hist_tick[s] == cmd.tick) begin
            hit          = 1'b1;
            r.found      = 1'b1;
            r.pending    = cmd.tick > hist_watermark;
            r.action_out = hist_action[s];
          end
        end
      end
      tkih_pkg::OP_LATEST: begin
        if (hist_live > 0) begin
          r.found      = 1'b1;
          r.action_out = hist_action[slot_at(hist_live - 1)];
        end
      end
      tkih_pkg::OP_CONFIRM: begin
        if (cmd.tick > hist_watermark) hist_watermark = cmd.tick;
      end
      tkih_pkg::OP_LIST: begin
        for (int unsigned i = 0; i < hist_live; i++) begin
          s = slot_at(i);
          if (hist_tick[s] > hist_watermark) begin
            e             = '0;
            e.entry_valid = 1'b1;
            e.entry_tick  = hist_tick[s];
            replies_due.insert(replies_due.size(), e);
            listed++;
          end
        end
      end
      tkih_pkg::OP_PRUNE: begin
        while (hist_live > 0 && hist_tick[hist_oldest] < cmd.tick) begin
          hist_oldest = slot_at(1);
          hist_live--;
        end
      end
      tkih_pkg::OP_CLEAR: begin
        hist_oldest    = 0;
        hist_live      = 0;
        hist_watermark = '0;
      end
      default: begin
      end
    endcase
    if (listed == 0) begin
      replies_due.insert(replies_due.size(), r);
    end else begin
      e      = replies_due.pop_back();
      e.last = 1'b1;
      replies_due.insert(replies_due.size(), e);
    end
  endfunction

  task automatic send_op(input logic [2:0] op, input logic [63:0] tick,
                         input logic [31:0] action);
    tkih_pkg::in_t cmd;
    int unsigned   gap;
    cmd.opcode    = op;
    cmd.tick      = tick;
    cmd.action_in = action;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= cmd;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    step_history(cmd);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk_i) begin : check_replies
    tkih_pkg::out_t want;
    if (rst_ni && res_strobe_o) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result with none expected, actual %0h", $time, res_o);
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        check_field("accepted", 64'(want.accepted), 64'(res_o.accepted));
        check_field("found", 64'(want.found), 64'(res_o.found));
        check_field("pending", 64'(want.pending), 64'(res_o.pending));
        check_field("action_out", 64'(want.action_out), 64'(res_o.action_out));
        check_field("entry_valid", 64'(want.entry_valid), 64'(res_o.entry_valid));
        check_field("entry_tick", want.entry_tick, res_o.entry_tick);
        check_field("last", 64'(want.last), 64'(res_o.last));
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_strobe_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_empty_buffer();
    send_op(tkih_pkg::OP_LOOKUP, '0, '0);
    send_op(tkih_pkg::OP_LATEST, '0, '0);
    send_op(tkih_pkg::OP_LIST, '0, '0);
    send_op(OP_UNUSED, TICK_MAX, '1);
  endtask

  task automatic test_extremes();
    send_op(tkih_pkg::OP_PUSH, '0, '0);
    send_op(tkih_pkg::OP_PUSH, '0, 32'h1234_5678);
    send_op(tkih_pkg::OP_PUSH, 64'd5, '1);
    send_op(tkih_pkg::OP_LOOKUP, '0, '0);
    send_op(tkih_pkg::OP_LOOKUP, 64'd5, '0);
    send_op(tkih_pkg::OP_LATEST, '0, '0);
    send_op(tkih_pkg::OP_LIST, '0, '0);
    send_op(tkih_pkg::OP_PUSH, TICK_MAX, 32'hA5A5_5A5A);
    send_op(tkih_pkg::OP_PUSH, 64'd7, 32'h0000_0001);
    send_op(tkih_pkg::OP_LOOKUP, TICK_MAX, '0);
    send_op(tkih_pkg::OP_CONFIRM, 64'd5, '0);
    send_op(tkih_pkg::OP_CONFIRM, 64'd3, '0);
    send_op(tkih_pkg::OP_LIST, '0, '0);
    send_op(tkih_pkg::OP_LOOKUP, 64'd5, '0);
    send_op(tkih_pkg::OP_PRUNE, 64'd5, '0);
    send_op(tkih_pkg::OP_LOOKUP, '0, '0);
    send_op(tkih_pkg::OP_CONFIRM, TICK_MAX, '0);
    send_op(tkih_pkg::OP_LIST, '0, '0);
    send_op(tkih_pkg::OP_PRUNE, TICK_MAX, '0);
    send_op(tkih_pkg::OP_LATEST, '0, '0);
    send_op(tkih_pkg::OP_CLEAR, '0, '0);
    send_op(tkih_pkg::OP_LIST, '0, '0);
  endtask

  task automatic test_wraparound();
    logic [63:0] t;
    logic [63:0] evicted;
    send_op(tkih_pkg::OP_CLEAR, '0, '0);
    t       = rand_tick() >> 8;
    evicted = t + 1;
    send_op(tkih_pkg::OP_PUSH, evicted, $urandom);
    t = evicted;
    for (int i = 0; i < 39; i++) begin
      t += $urandom_range(1, 50);
      send_op(tkih_pkg::OP_PUSH, t, $urandom);
    end
    send_op(tkih_pkg::OP_LIST, '0, '0);
    send_op(tkih_pkg::OP_LOOKUP, evicted, '0);
    send_op(tkih_pkg::OP_LOOKUP, hist_tick[hist_oldest], '0);
    send_op(tkih_pkg::OP_CONFIRM, hist_tick[slot_at(15)], '0);
    send_op(tkih_pkg::OP_LIST, '0, '0);
    send_op(tkih_pkg::OP_PRUNE, hist_tick[slot_at(20)], '0);
    send_op(tkih_pkg::OP_LIST, '0, '0);
    send_op(tkih_pkg::OP_LATEST, '0, '0);
    for (int i = 0; i < 4; i++) begin
      t += $urandom_range(1, 50);
      send_op(tkih_pkg::OP_PUSH, t, $urandom);
    end
  endtask

  task automatic test_random_mix(int unsigned count);
    int unsigned pick;
    logic [63:0] t;
    tick_base = rand_tick() >> $urandom_range(0, 40);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 20 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if ($urandom_range(0, 9) == 0) t = newest_tick() - $urandom_range(0, 3);
        else t = newest_tick() + $urandom_range(1, 1000);
        send_op(tkih_pkg::OP_PUSH, t, $urandom);
      end else if (pick < 58) begin
        if (hist_live > 0 && $urandom_range(0, 3) != 0) t = stored_tick();
        else if ($urandom_range(0, 1) == 0) t = newest_tick() + $urandom_range(1, 5);
        else t = rand_tick();
        send_op(tkih_pkg::OP_LOOKUP, t, $urandom);
      end else if (pick < 63) begin
        send_op(tkih_pkg::OP_LATEST, rand_tick(), $urandom);
      end else if (pick < 73) begin
        if (hist_live > 0 && $urandom_range(0, 3) != 0) t = stored_tick();
        else t = hist_watermark - $urandom_range(0, 2);
        send_op(tkih_pkg::OP_CONFIRM, t, $urandom);
      end else if (pick < 85) begin
        send_op(tkih_pkg::OP_LIST, rand_tick(), $urandom);
      end else if (pick < 93) begin
        if (hist_live > 0 && $urandom_range(0, 4) != 0) t = stored_tick();
        else t = newest_tick() + 1;
        send_op(tkih_pkg::OP_PRUNE, t, $urandom);
      end else if (pick < 97) begin
        send_op(tkih_pkg::OP_CLEAR, rand_tick(), $urandom);
        tick_base = rand_tick() >> $urandom_range(0, 40);
      end else begin
        send_op(OP_UNUSED, rand_tick(), $urandom);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_buffer();
    test_extremes();
    test_wraparound();
    test_random_mix(150);
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
